FILE: rtl/core/cooperative_task_scheduler_table_top_assert.svh
// Assertion macros used by the task scheduler table RTL.
`ifndef COOPERATIVE_TASK_SCHEDULER_TABLE_TOP_ASSERT_SVH
`define COOPERATIVE_TASK_SCHEDULER_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cts: assertion failed");
`define CTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cts: assertion failed");
`else
`define CTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/cts_pkg.sv
// Types and constants of the task scheduler table.
package cts_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int MAX_OUT    = 8;
    localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W      = $clog2(MAX_OUT + 1);
    localparam int SLOT_W     = 6;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_DISPATCH = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HANDLE = 3'd1,
        ST_FULL       = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_RANGE      = 3'd4,
        ST_NONE_READY = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PROC,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] task_handle;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_index;
        logic [15:0]       run_handle;
        logic [2:0]        last_error;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] delay;
        logic [31:0] period;
        logic        ready;
    } t_entry;

    typedef struct packed {
        logic             ren;
        logic [IDX_W-1:0] raddr;
        logic             wen;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_mem_req;

endpackage

FILE: rtl/core/cts_mem.sv
// Slot table memory with per-entry valid bits; an unwritten entry reads as an empty slot.
module cts_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cts_pkg::t_mem_req i_req,
    output cts_pkg::t_entry   o_rdata
);
    import cts_pkg::*;

    t_entry mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] r_vld;
    t_entry r_rdata;
    logic   r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_req.wen) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.ren) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.wen) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            if (i_req.ren) begin
                r_rvld <= r_vld[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

FILE: rtl/core/cts_seq.sv
// Command sequencer: sweeps the slot table through the memory and issues result items.
`include "cooperative_task_scheduler_table_top_assert.svh"

module cts_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cts_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cts_pkg::t_out_item o_out_item,
    output cts_pkg::t_mem_req  o_mem_req,
    input  cts_pkg::t_entry    i_rdata
);
    import cts_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [15:0]       r_handle, n_handle;
    logic [31:0]       r_delay, n_delay;
    logic [31:0]       r_period, n_period;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_n, n_n;
    t_out_item         r_res, n_res;
    logic [2:0]        r_sticky, n_sticky;
    logic              r_out_valid;
    t_out_item         r_out;

    t_mem_req          s_mem_req;
    logic              s_out_free;
    logic              s_load;
    logic              s_load_last;
    logic              s_last_slot;
    logic [IDX_W-1:0]  s_idx_next;
    logic [CNT_W-1:0]  s_n_inc;
    t_entry            s_tick;
    t_out_item         s_out_next;

    assign s_out_free  = !r_out_valid || !i_out_stall;
    assign s_last_slot = (r_idx == LAST_IDX);
    assign s_idx_next  = r_idx + IDX_W'(1);
    assign s_n_inc     = r_n + CNT_W'(1);

    // Tick update of one occupied slot.
    always_comb begin
        s_tick = i_rdata;
        if (i_rdata.delay == 32'd0) begin
            s_tick.ready = 1'b1;
            if (i_rdata.period != 32'd0) begin
                s_tick.delay = i_rdata.period;
            end
        end else begin
            s_tick.delay = i_rdata.delay - 32'd1;
        end
    end

    always_comb begin
        s_out_next            = r_res;
        s_out_next.last_error = r_sticky;
        s_out_next.last       = s_load_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sticky    <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sticky <= n_sticky;
            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_handle <= n_handle;
        r_delay  <= n_delay;
        r_period <= n_period;
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_res    <= n_res;
        if (s_load) begin
            r_out <= s_out_next;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_cmd            = r_cmd;
        n_handle         = r_handle;
        n_delay          = r_delay;
        n_period         = r_period;
        n_idx            = r_idx;
        n_n              = r_n;
        n_res            = r_res;
        n_sticky         = r_sticky;
        s_load           = 1'b0;
        s_load_last      = 1'b0;
        s_mem_req        = '0;
        s_mem_req.raddr  = r_idx;
        s_mem_req.waddr  = r_idx;
        s_mem_req.wdata  = i_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = t_cmd'(i_in_item.command);
                    n_handle = i_in_item.task_handle;
                    n_delay  = i_in_item.delay;
                    n_period = i_in_item.period;
                    n_idx    = '0;
                    n_n      = '0;
                    n_res    = '0;
                    n_state  = S_READ;
                    case (t_cmd'(i_in_item.command))
                        CMD_ADD: begin
                            if (i_in_item.task_handle == 16'd0) begin
                                n_sticky         = ST_BAD_HANDLE;
                                n_res.status     = ST_BAD_HANDLE;
                                n_state          = S_REPORT;
                            end
                        end
                        CMD_DELETE: begin
                            if (i_in_item.slot >= 8'(TASK_SLOTS)) begin
                                n_sticky     = ST_RANGE;
                                n_res.status = ST_RANGE;
                                n_state      = S_REPORT;
                            end else begin
                                n_idx = i_in_item.slot[IDX_W-1:0];
                            end
                        end
                        CMD_TICK, CMD_DISPATCH: begin
                            n_idx = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_READ: begin
                s_mem_req.ren = 1'b1;
                n_state       = S_PROC;
            end

            S_PROC: begin
                case (r_cmd)
                    CMD_ADD: begin
                        if (i_rdata.handle == 16'd0) begin
                            s_mem_req.wen          = 1'b1;
                            s_mem_req.wdata.handle = r_handle;
                            s_mem_req.wdata.delay  = r_delay;
                            s_mem_req.wdata.period = r_period;
                            s_mem_req.wdata.ready  = 1'b0;
                            n_res.status           = ST_OK;
                            n_res.slot_index       = SLOT_W'(r_idx);
                            n_state                = S_REPORT;
                        end else if (s_last_slot) begin
                            n_sticky         = ST_FULL;
                            n_res.status     = ST_FULL;
                            n_res.slot_index = SLOT_W'(TASK_SLOTS);
                            n_state          = S_REPORT;
                        end else begin
                            s_mem_req.ren   = 1'b1;
                            s_mem_req.raddr = s_idx_next;
                            n_idx           = s_idx_next;
                        end
                    end
                    CMD_DELETE: begin
                        // An empty slot is cleared all the same.
                        s_mem_req.wen    = 1'b1;
                        s_mem_req.wdata  = '0;
                        n_res.slot_index = SLOT_W'(r_idx);
                        if (i_rdata.handle == 16'd0) begin
                            n_sticky     = ST_EMPTY;
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_res.status = ST_OK;
                        end
                        n_state = S_REPORT;
                    end
                    CMD_TICK: begin
                        s_mem_req.wen   = (i_rdata.handle != 16'd0);
                        s_mem_req.wdata = s_tick;
                        if (s_last_slot) begin
                            n_res   = '0;
                            n_state = S_REPORT;
                        end else begin
                            s_mem_req.ren   = 1'b1;
                            s_mem_req.raddr = s_idx_next;
                            n_idx           = s_idx_next;
                        end
                    end
                    CMD_DISPATCH: begin
                        // One dispatched item is held back until it is known
                        // whether another follows, so that it can carry last.
                        if (i_rdata.ready) begin
                            if (r_n == '0 || s_out_free) begin
                                s_load               = (r_n != '0);
                                s_load_last          = 1'b0;
                                s_mem_req.wen        = 1'b1;
                                s_mem_req.wdata.ready = 1'b0;
                                if (i_rdata.period == 32'd0) begin
                                    s_mem_req.wdata = '0;
                                end
                                n_res.status     = ST_OK;
                                n_res.slot_index = SLOT_W'(r_idx);
                                n_res.run_handle = i_rdata.handle;
                                n_n              = s_n_inc;
                                if (s_last_slot || s_n_inc == CNT_W'(MAX_OUT)) begin
                                    n_state = S_REPORT;
                                end else begin
                                    s_mem_req.ren   = 1'b1;
                                    s_mem_req.raddr = s_idx_next;
                                    n_idx           = s_idx_next;
                                end
                            end
                        end else if (s_last_slot) begin
                            if (r_n == '0) begin
                                n_res        = '0;
                                n_res.status = ST_NONE_READY;
                            end
                            n_state = S_REPORT;
                        end else begin
                            s_mem_req.ren   = 1'b1;
                            s_mem_req.raddr = s_idx_next;
                            n_idx           = s_idx_next;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_REPORT: begin
                if (s_out_free) begin
                    s_load      = 1'b1;
                    s_load_last = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_mem_req   = s_mem_req;

    `CTS_ASSERT_IMP(a_rw_distinct, i_clk, i_rst_n, s_mem_req.wen && s_mem_req.ren, s_mem_req.waddr != s_mem_req.raddr)
    `CTS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, r_state == S_PROC, r_n <= CNT_W'(MAX_OUT))
    `CTS_ASSERT_IMP(a_early_only_dispatch, i_clk, i_rst_n, s_load && !s_load_last, r_cmd == CMD_DISPATCH)
    `CTS_ASSERT_NXT(a_read_then_proc, i_clk, i_rst_n, r_state == S_READ, r_state == S_PROC)

endmodule

FILE: rtl/core/cooperative_task_scheduler_table_top.sv
// Add sweeps the slots from the first until it finds a free one; tick and dispatch
// sweep every slot; delete reads and clears the named slot; a rejected add or delete
// goes straight to the report. Only one item is taken at a time; a sweep visits one
// slot per cycle over the single memory read port, but a dispatch sweep waits while
// an earlier result item is stalled. Reset is synchronous and active low; it empties
// every slot at once and clears the sticky error.
module cooperative_task_scheduler_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cts_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cts_pkg::t_out_item o_out_item
);
    import cts_pkg::*;

    t_mem_req s_mem_req;
    t_entry   s_rdata;

    cts_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_mem_req   (s_mem_req),
        .i_rdata     (s_rdata)
    );

    cts_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_mem_req),
        .o_rdata (s_rdata)
    );

endmodule
